/* design/zero_terminated_message_fifo_unit_assert.svh */
// Assertion macros for the zero-terminated message FIFO.
`ifndef ZERO_TERMINATED_MESSAGE_FIFO_UNIT_ASSERT_SVH
`define ZERO_TERMINATED_MESSAGE_FIFO_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define ZMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("zmf assertion failed");

`define ZMF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("zmf forbidden condition seen");

`else

`define ZMF_ASSERT(lbl, clk, rst_n, prop)

`define ZMF_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* design/zmf_pkg.sv */
// Shared types and constants of the zero-terminated message FIFO.
package zmf_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 7;
    localparam int LEN_W  = 6;
    localparam int ST_W   = 3;
    localparam int QDEPTH = 2;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_cmd_kind;

    typedef enum logic [ST_W-1:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_MSG     = 3'd2,
        ST_NOMSG   = 3'd3,
        ST_TOOLONG = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data;
        logic [CAP_W-1:0]  cap;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        t_status           status;
        logic [LEN_W-1:0]  msg_length;
        logic              overflow_seen;
    } t_result;

endpackage

/* design/zmf_ifs.sv */
// Handshake interfaces for the request and result channels.
interface zmf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [zmf_pkg::BYTE_W-1:0]  rx_byte;
    logic [zmf_pkg::CAP_W-1:0]   dest_capacity;

    modport source (output valid, output operation, output rx_byte, output dest_capacity,
                    input ready);
    modport sink   (input valid, input operation, input rx_byte, input dest_capacity,
                    output ready);
endinterface

interface zmf_out_if;
    logic                        valid;
    logic                        ready;
    logic [zmf_pkg::BYTE_W-1:0]  out_byte;
    logic                        last;
    logic [zmf_pkg::ST_W-1:0]    status;
    logic [zmf_pkg::LEN_W-1:0]   msg_length;
    logic                        overflow_seen;

    modport source (output valid, output out_byte, output last, output status,
                    output msg_length, output overflow_seen, input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    input msg_length, input overflow_seen, output ready);
endinterface

/* design/zmf_front.sv */
// Front end: takes request transactions and turns them into queued commands.
module zmf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    zmf_in_if.sink        i_in,
    output logic          o_cmd_valid,
    output zmf_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);

    logic          r_valid;
    logic          n_valid;
    zmf_pkg::t_cmd r_cmd;
    zmf_pkg::t_cmd n_cmd;
    logic          w_take;

    assign i_in.ready = !r_valid || i_cmd_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (w_take) begin
            n_valid    = 1'b1;
            n_cmd.kind = i_in.operation ? zmf_pkg::CMD_READ : zmf_pkg::CMD_PUSH;
            n_cmd.data = i_in.rx_byte;
            n_cmd.cap  = i_in.dest_capacity;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

/* design/zmf_cmdq.sv */
// Short command queue between the front end and the execution engine.
module zmf_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  zmf_pkg::t_cmd i_wr_cmd,
    output logic          o_wr_ready,
    output logic          o_rd_valid,
    output zmf_pkg::t_cmd o_rd_cmd,
    input  logic          i_rd_ready
);

    localparam int QW = (zmf_pkg::QDEPTH > 1) ? $clog2(zmf_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(zmf_pkg::QDEPTH + 1);

    zmf_pkg::t_cmd r_mem [zmf_pkg::QDEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    function automatic logic [QW-1:0] f_adv(input logic [QW-1:0] p);
        return (p == QW'(zmf_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_wr_ready = (r_cnt != CW'(zmf_pkg::QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_cmd   = r_mem[r_rp];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= f_adv(r_wp);
            end
            if (w_pop) begin
                r_rp <= f_adv(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

endmodule

/* design/zmf_back.sv */
// Execution engine: byte ring, terminator scan and message read-out.
`include "zero_terminated_message_fifo_unit_assert.svh"

module zmf_back #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  zmf_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    zmf_out_if.source     o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_iss, n_iss;
    logic          r_chk_valid, n_chk_valid;
    logic [AW-1:0] r_chk_i, n_chk_i;
    logic [AW-1:0] r_len, n_len;
    logic [AW-1:0] r_emit_i, n_emit_i;
    logic          r_primed, n_primed;
    logic [zmf_pkg::CAP_W-1:0] r_cap, n_cap;
    zmf_pkg::t_status r_resp, n_resp;
    logic             r_out_valid, n_out_valid;
    zmf_pkg::t_result r_out, n_out;

    logic [zmf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [zmf_pkg::BYTE_W-1:0] r_rd_data;

    logic             w_we;
    logic [AW-1:0]    w_rd_addr;
    logic [AW:0]      w_count_ext;
    logic [AW-1:0]    w_count;
    logic             w_full;
    logic             w_slot_free;
    logic             w_load;
    logic             w_last_byte;
    zmf_pkg::t_result w_ld_res;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // ring occupancy, never more than DEPTH-1
    assign w_count_ext = (r_wr_idx >= r_rd_idx)
                       ? ({1'b0, r_wr_idx} - {1'b0, r_rd_idx})
                       : ({1'b0, r_wr_idx} + (AW+1)'(DEPTH) - {1'b0, r_rd_idx});
    assign w_count     = w_count_ext[AW-1:0];
    assign w_full      = (w_count == AW'(DEPTH - 1));
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_last_byte = (r_emit_i == r_len);
    assign o_cmd_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_ovf       = r_ovf;
        n_ptr       = r_ptr;
        n_iss       = r_iss;
        n_chk_valid = r_chk_valid;
        n_chk_i     = r_chk_i;
        n_len       = r_len;
        n_emit_i    = r_emit_i;
        n_primed    = r_primed;
        n_cap       = r_cap;
        n_resp      = r_resp;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_rd_addr   = r_ptr;
        w_load      = 1'b0;
        w_ld_res    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == zmf_pkg::CMD_PUSH) begin
                        if (w_full) begin
                            n_ovf  = 1'b1;
                            n_resp = zmf_pkg::ST_DROPPED;
                        end else begin
                            w_we     = 1'b1;
                            n_wr_idx = f_next(r_wr_idx);
                            n_resp   = zmf_pkg::ST_STORED;
                        end
                        n_state = S_RESP;
                    end else if (w_count == '0) begin
                        n_resp  = zmf_pkg::ST_NOMSG;
                        n_state = S_RESP;
                    end else begin
                        n_cap       = i_cmd.cap;
                        n_ptr       = r_rd_idx;
                        n_iss       = '0;
                        n_chk_valid = 1'b0;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one read issued per cycle, its data checked in the following cycle
                n_chk_valid = 1'b0;
                if (r_iss < w_count) begin
                    w_rd_addr   = r_ptr;
                    n_ptr       = f_next(r_ptr);
                    n_iss       = r_iss + 1'b1;
                    n_chk_valid = 1'b1;
                    n_chk_i     = r_iss;
                end
                if (r_chk_valid) begin
                    if (r_rd_data == '0) begin
                        if (zmf_pkg::CAP_W'(r_chk_i) >= r_cap) begin
                            n_resp  = zmf_pkg::ST_TOOLONG;
                            n_state = S_RESP;
                        end else begin
                            n_len    = r_chk_i;
                            n_ptr    = r_rd_idx;
                            n_emit_i = '0;
                            n_primed = 1'b0;
                            n_state  = S_EMIT;
                        end
                    end else if (r_chk_i == w_count - 1'b1) begin
                        n_resp  = zmf_pkg::ST_NOMSG;
                        n_state = S_RESP;
                    end
                end
            end
            S_EMIT: begin
                // read address runs one ahead when a byte leaves
                n_primed = 1'b1;
                if (r_primed && w_slot_free) begin
                    w_load                 = 1'b1;
                    w_ld_res.out_byte      = r_rd_data;
                    w_ld_res.last          = w_last_byte;
                    w_ld_res.status        = zmf_pkg::ST_MSG;
                    w_ld_res.msg_length    = zmf_pkg::LEN_W'(r_len);
                    w_ld_res.overflow_seen = r_ovf;
                    w_rd_addr              = f_next(r_ptr);
                    n_ptr                  = f_next(r_ptr);
                    n_emit_i               = r_emit_i + 1'b1;
                    if (w_last_byte) begin
                        n_rd_idx = f_next(r_ptr);
                        n_state  = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (w_slot_free) begin
                    w_load                 = 1'b1;
                    w_ld_res.out_byte      = '0;
                    w_ld_res.last          = 1'b1;
                    w_ld_res.status        = r_resp;
                    w_ld_res.msg_length    = '0;
                    w_ld_res.overflow_seen = r_ovf;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = w_ld_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_ovf       <= 1'b0;
            r_chk_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_ovf       <= n_ovf;
            r_chk_valid <= n_chk_valid;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_iss    <= n_iss;
        r_chk_i  <= n_chk_i;
        r_len    <= n_len;
        r_emit_i <= n_emit_i;
        r_cap    <= n_cap;
        r_resp   <= n_resp;
        r_out    <= n_out;
    end

    // byte ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_idx] <= i_cmd.data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.last          = r_out.last;
    assign o_out.status        = r_out.status;
    assign o_out.msg_length    = r_out.msg_length;
    assign o_out.overflow_seen = r_out.overflow_seen;

    `ZMF_ASSERT_NEVER(a_wr_idx_range, i_clk, i_rst_n, {1'b0, r_wr_idx} >= (AW+1)'(DEPTH))
    `ZMF_ASSERT(a_drop_keeps_wr, i_clk, i_rst_n, (r_state == S_IDLE && i_cmd_valid && i_cmd.kind == zmf_pkg::CMD_PUSH && w_full) |=> ($stable(r_wr_idx) && r_ovf))
    `ZMF_ASSERT(a_rd_moves_on_last, i_clk, i_rst_n, (r_rd_idx != $past(r_rd_idx)) |-> $past(w_load && r_state == S_EMIT && w_last_byte))

endmodule

/* design/zero_terminated_message_fifo_unit.sv */
// Push: the engine stores the byte, then hands its result on before it takes the next command.
// Read: the engine scans the ring one byte a cycle over its single read port, then streams
// the message one byte a cycle while the result output is not held back by ready.
// A two-entry command queue lets requests be taken while a read is streaming out.
// Synchronous active-low reset empties the ring, clears overflow; no clearing pass.
module zero_terminated_message_fifo_unit #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    zmf_in_if.sink    i_in,
    zmf_out_if.source o_out
);

    logic          w_f_valid;
    zmf_pkg::t_cmd w_f_cmd;
    logic          w_f_ready;
    logic          w_q_valid;
    zmf_pkg::t_cmd w_q_cmd;
    logic          w_q_ready;

    zmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_f_valid),
        .o_cmd       (w_f_cmd),
        .i_cmd_ready (w_f_ready)
    );

    zmf_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .i_wr_cmd   (w_f_cmd),
        .o_wr_ready (w_f_ready),
        .o_rd_valid (w_q_valid),
        .o_rd_cmd   (w_q_cmd),
        .i_rd_ready (w_q_ready)
    );

    zmf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_ready (w_q_ready),
        .o_out       (o_out)
    );

endmodule

/* test/zero_terminated_message_fifo_unit_test.sv */
// Testbench for the zero-terminated message FIFO: directed table, random traffic, ring predictor.
`timescale 1ns / 1ps

module zero_terminated_message_fifo_unit_test;

    localparam int RING_DEPTH = 64;
    localparam int DIR_ROWS   = 22;
    localparam int RAND_ITEMS = 108;

    typedef struct {
        zmf_pkg::t_cmd_kind kind;
        logic [7:0]         data;
        logic [6:0]         cap;
        bit                 typed;
        zmf_pkg::t_result   want;
    } step_row_t;

    logic i_clk;
    logic i_rst_n;

    zmf_in_if  in_bus ();
    zmf_out_if out_bus ();

    zero_terminated_message_fifo_unit #(
        .DEPTH (RING_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predictor state
    logic [7:0] ring_mem [RING_DEPTH];
    logic [5:0] ring_rd;
    logic [5:0] ring_wr;
    logic       ring_ovf;

    zmf_pkg::t_result pending_results [$];
    int               fails;
    int               sent;
    bit               quiet;
    step_row_t        dir_rows [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [5:0] ring_held();
        return ring_wr - ring_rd;
    endfunction

    // Length of the message at the head of the ring, or -1 if no terminator is held.
    function automatic int term_pos();
        logic [5:0] held;
        held = ring_held();
        for (int i = 0; i < int'(held); i++) begin
            if (ring_mem[6'(ring_rd + 6'(i))] == 8'h00) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic fifo_model_step(input zmf_pkg::t_cmd_kind k, input logic [7:0] b,
                                   input logic [6:0] c, input bit enq);
        zmf_pkg::t_result r;
        int               len;
        r = '0;
        r.last = 1'b1;
        if (k == zmf_pkg::CMD_PUSH) begin
            if (ring_held() >= 6'(RING_DEPTH - 1)) begin
                ring_ovf = 1'b1;
                r.status = zmf_pkg::ST_DROPPED;
            end else begin
                ring_mem[ring_wr] = b;
                ring_wr = ring_wr + 6'd1;
                r.status = zmf_pkg::ST_STORED;
            end
            r.overflow_seen = ring_ovf;
            if (enq) pending_results.push_back(r);
        end else begin
            len = term_pos();
            r.overflow_seen = ring_ovf;
            if (len < 0 || len >= int'(c)) begin
                r.status = (len < 0) ? zmf_pkg::ST_NOMSG : zmf_pkg::ST_TOOLONG;
                if (enq) pending_results.push_back(r);
            end else begin
                for (int i = 0; i <= len; i++) begin
                    r.out_byte   = ring_mem[ring_rd];
                    r.last       = (i == len);
                    r.status     = zmf_pkg::ST_MSG;
                    r.msg_length = 6'(len);
                    ring_rd = ring_rd + 6'd1;
                    if (enq) pending_results.push_back(r);
                end
            end
        end
    endtask

    task automatic send_item(input zmf_pkg::t_cmd_kind k, input logic [7:0] b,
                             input logic [6:0] c, input bit typed,
                             input zmf_pkg::t_result want);
        while (!quiet && $urandom_range(99) < 8) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.operation     <= k;
        in_bus.rx_byte       <= b;
        in_bus.dest_capacity <= c;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        fifo_model_step(k, b, c, !typed);
        if (typed) pending_results.push_back(want);
        sent++;
        quiet = (sent >= DIR_ROWS + 50) && (sent < DIR_ROWS + 90);
    endtask

    task automatic send(input zmf_pkg::t_cmd_kind k, input logic [7:0] b, input logic [6:0] c);
        send_item(k, b, c, 1'b0, '0);
    endtask

    // Keeps the ring from filling up with no terminator, which would block reads for good.
    task automatic rand_push(input logic [7:0] b);
        if (ring_held() >= 6'd61 && term_pos() < 0) b = 8'h00;
        send(zmf_pkg::CMD_PUSH, b, 7'($urandom_range(127)));
    endtask

    task automatic message_burst();
        int n;
        int tp;
        int r;
        logic [6:0] cap;
        n = ($urandom_range(9) == 0) ? $urandom_range(62, 20) : $urandom_range(6, 0);
        for (int i = 0; i < n; i++) rand_push(8'($urandom_range(255, 1)));
        rand_push(8'h00);
        if ($urandom_range(3) != 0) begin
            tp = term_pos();
            r  = $urandom_range(9);
            if (tp < 0)      cap = 7'($urandom_range(127));
            else if (r < 6)  cap = 7'($urandom_range(64, tp + 1));
            else if (r < 8)  cap = 7'($urandom_range(tp, 0));
            else if (r == 8) cap = 7'd0;
            else             cap = 7'($urandom_range(127, 65));
            send(zmf_pkg::CMD_READ, 8'($urandom_range(255)), cap);
        end
    endtask

    // Fill the ring to the brim, terminator last, overflow it, then drain every message.
    task automatic flood();
        int extra;
        while (ring_held() < 6'd62) rand_push(8'($urandom_range(255, 1)));
        send(zmf_pkg::CMD_PUSH, 8'h00, 7'($urandom_range(127)));
        extra = $urandom_range(4, 2);
        for (int i = 0; i < extra; i++) begin
            send(zmf_pkg::CMD_PUSH, 8'($urandom_range(255)), 7'd0);
        end
        while (term_pos() >= 0) send(zmf_pkg::CMD_READ, 8'($urandom_range(255)), 7'd64);
    endtask

    always @(posedge i_clk) begin
        out_bus.ready <= i_rst_n && (quiet || $urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin : result_check
        zmf_pkg::t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction pending: status %0d", out_bus.status);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (out_bus.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, out_bus.out_byte);
                    fails++;
                end
                if (out_bus.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_bus.last);
                    fails++;
                end
                if (out_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_bus.status);
                    fails++;
                end
                if (out_bus.msg_length !== want.msg_length) begin
                    $error("msg_length: expected %0d, got %0d", want.msg_length,
                           out_bus.msg_length);
                    fails++;
                end
                if (out_bus.overflow_seen !== want.overflow_seen) begin
                    $error("overflow_seen: expected %0d, got %0d", want.overflow_seen,
                           out_bus.overflow_seen);
                    fails++;
                end
            end
        end
    end

    initial begin
        int kind;
        bit flooded;
        int waited;
        fails   = 0;
        sent    = 0;
        quiet   = 1'b0;
        flooded = 1'b0;
        ring_rd  = '0;
        ring_wr  = '0;
        ring_ovf = 1'b0;
        i_rst_n              <= 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.operation     <= zmf_pkg::CMD_PUSH;
        in_bus.rx_byte       <= '0;
        in_bus.dest_capacity <= '0;

        dir_rows = '{
            '{zmf_pkg::CMD_READ, 8'h00, 7'd10,  1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_NOMSG,   6'd0, 1'b0}},
            '{zmf_pkg::CMD_PUSH, 8'h00, 7'd0,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_STORED,  6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd0,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_TOOLONG, 6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd1,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_MSG,     6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'hFF, 7'd127, 1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_NOMSG,   6'd0, 1'b0}},
            '{zmf_pkg::CMD_PUSH, 8'hFF, 7'd127, 1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_STORED,  6'd0, 1'b0}},
            '{zmf_pkg::CMD_PUSH, 8'h80, 7'd0,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_STORED,  6'd0, 1'b0}},
            '{zmf_pkg::CMD_PUSH, 8'h01, 7'd64,  1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'h7F, 7'd1,   1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'h00, 7'd0,   1'b0, '0},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd4,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_TOOLONG, 6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd5,   1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'h55, 7'd127, 1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'hAA, 7'd0,   1'b0, '0},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd64,  1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_NOMSG,   6'd0, 1'b0}},
            '{zmf_pkg::CMD_PUSH, 8'h00, 7'd3,   1'b0, '0},
            '{zmf_pkg::CMD_READ, 8'hFF, 7'd64,  1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'h00, 7'd0,   1'b0, '0},
            '{zmf_pkg::CMD_PUSH, 8'h00, 7'd0,   1'b0, '0},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd127, 1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_MSG,     6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd2,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_MSG,     6'd0, 1'b0}},
            '{zmf_pkg::CMD_READ, 8'h00, 7'd1,   1'b1,
              '{8'h00, 1'b1, zmf_pkg::ST_NOMSG,   6'd0, 1'b0}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].cap,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        while (sent < DIR_ROWS + RAND_ITEMS) begin
            kind = $urandom_range(99);
            if (!flooded && (kind < 8 || sent > DIR_ROWS + 40)) begin
                flood();
                flooded = 1'b1;
            end else if (kind < 75) begin
                message_burst();
            end else if ($urandom_range(1) == 0) begin
                rand_push(8'($urandom_range(255)));
            end else begin
                send(zmf_pkg::CMD_READ, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end
        end
        in_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < 2 * RING_DEPTH + 10) begin
            @(posedge i_clk);
            waited++;
        end

        if (fails == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
